FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold whenever the antecedent holds, outside reset.
`define APB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("%m: implication check failed");

// The expression must hold at every clock edge outside reset.
`define APB_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("%m: invariant check failed");

`endif

FILE: hdl/apb_pkg.sv
// ----------------------------------------------------------------------------
// Alpha blender package
// Types, constants and codes shared by the blender modules.
// ----------------------------------------------------------------------------
package apb_pkg;

   localparam int LANES   = 4;
   localparam int NUM_W   = 34;
   localparam int DEN_W   = 24;
   localparam int REM_W   = 32;
   localparam int Q_W     = 8;
   localparam int LATENCY = 13;

   localparam logic [15:0] FULL2 = 16'd65025;
   localparam logic [23:0] FULL3 = 24'd16581375;
   localparam logic [7:0]  BYTE_MAX = 8'hff;

   typedef enum logic [3:0] {
      MODE_RGB_N = 4'd0,
      MODE_RGB_P = 4'd1,
      MODE_N_EN  = 4'd2,
      MODE_N_EP  = 4'd3,
      MODE_N_NN  = 4'd4,
      MODE_N_NP  = 4'd5,
      MODE_P_EN  = 4'd6,
      MODE_P_EP  = 4'd7,
      MODE_P_PN  = 4'd8,
      MODE_P_PP  = 4'd9
   } apb_mode_type;

   typedef enum logic [2:0] {
      REG_BLEND_MODE     = 3'd0,
      REG_GLOBAL_ALPHA   = 3'd1,
      REG_USE_MASK       = 3'd2,
      REG_FILL_COLOR     = 3'd3,
      REG_USE_FILL_COLOR = 3'd4
   } apb_reg_type;

   typedef struct packed {
      logic [7:0] dst_red;
      logic [7:0] dst_green;
      logic [7:0] dst_blue;
      logic [7:0] dst_alpha;
      logic [7:0] src_red;
      logic [7:0] src_green;
      logic [7:0] src_blue;
      logic [7:0] src_alpha;
      logic [7:0] mask_value;
   } apb_req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
   } apb_rsp_type;

   typedef struct packed {
      logic [3:0]  blend_mode;
      logic [7:0]  global_alpha;
      logic        use_mask;
      logic [31:0] fill_color;
      logic        use_fill_color;
   } apb_cfg_type;

   typedef struct packed {
      logic                        valid;
      logic [LANES-1:0][NUM_W-1:0] num;
      logic [LANES-1:0][DEN_W-1:0] den;
   } apb_div_in_type;

   typedef struct packed {
      logic                      valid;
      logic [LANES-1:0][Q_W-1:0] quo;
   } apb_div_out_type;

endpackage

FILE: hdl/apb_prep.sv
// ----------------------------------------------------------------------------
// Blend operand preparation
// Three register stages that form the dividend and divisor of every channel.
// ----------------------------------------------------------------------------
module apb_prep (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  apb_pkg::apb_req_type  req_data,
   input  apb_pkg::apb_cfg_type  cfg,
   output apb_pkg::apb_div_in_type div_in
);
   import apb_pkg::*;

   logic        v1_ff, v2_ff;
   logic [3:0]  mode1_ff, mode1_in, mode2_ff;
   logic [7:0]  a1_ff, a1_in;
   logic [15:0] k1_ff, k1_in, k2_ff;
   logic [7:0]  s1_ff [LANES], s1_in [LANES], s2_ff [LANES];
   logic [7:0]  d1_ff [LANES], d1_in [LANES], d2_ff [LANES];
   logic [15:0] inv;
   logic [23:0] ind_ff [3], ind_in [3];
   logic [23:0] ks_ff [3], ks_in [3];
   logic [15:0] as_ff [3], as_in [3];
   logic [23:0] ina_ff, ina_in, invd3_ff, invd3_in;
   logic [23:0] newa;
   logic [31:0] prod [3];
   logic [NUM_W-1:0] fg4 [3], fg5 [3];
   apb_div_in_type div_ff, div_in_next;

   always_comb begin
      a1_in = cfg.use_mask ? req_data.mask_value : cfg.global_alpha;
      d1_in[0] = req_data.dst_red;
      d1_in[1] = req_data.dst_green;
      d1_in[2] = req_data.dst_blue;
      d1_in[3] = req_data.dst_alpha;
      s1_in[0] = req_data.src_red;
      s1_in[1] = req_data.src_green;
      s1_in[2] = req_data.src_blue;
      s1_in[3] = req_data.src_alpha;
      mode1_in = cfg.blend_mode;
      if (cfg.use_fill_color && cfg.blend_mode <= MODE_P_PP) begin
         s1_in[0] = cfg.fill_color[31:24];
         s1_in[1] = cfg.fill_color[23:16];
         s1_in[2] = cfg.fill_color[15:8];
         s1_in[3] = cfg.fill_color[7:0];
         mode1_in[0] = 1'b0;
      end
      if ((mode1_in inside {MODE_N_NN, MODE_N_NP}) && d1_in[3] == 8'd0) begin
         mode1_in = mode1_in - 4'd2;
      end
      k1_in = 16'(a1_in) * 16'(s1_in[3]);
   end

   always_comb begin
      inv = FULL2 - k1_ff;
      for (int i = 0; i < 3; i++) begin
         ind_in[i] = 24'(inv) * 24'(d1_ff[i]);
         ks_in[i]  = 24'(k1_ff) * 24'(s1_ff[i]);
         as_in[i]  = 16'(a1_ff) * 16'(s1_ff[i]);
      end
      ina_in   = 24'(inv) * 24'(BYTE_MAX - d1_ff[3]);
      invd3_in = 24'(inv) * 24'(d1_ff[3]);
   end

   always_comb begin
      newa = FULL3 - ina_ff;
      div_in_next.valid = v2_ff;
      for (int i = 0; i < 3; i++) begin
         prod[i] = 32'(invd3_ff) * 32'(d2_ff[i]);
         fg4[i]  = (NUM_W'(ks_ff[i]) << 8) - NUM_W'(ks_ff[i]);
         fg5[i]  = (NUM_W'(as_ff[i]) << 16) - (NUM_W'(as_ff[i]) << 9) + NUM_W'(as_ff[i]);
         div_in_next.num[i] = NUM_W'(d2_ff[i]);
         div_in_next.den[i] = DEN_W'(1);
         case (mode2_ff)
            MODE_RGB_N, MODE_P_PN: begin
               div_in_next.num[i] = NUM_W'(ind_ff[i]) + NUM_W'(ks_ff[i]);
               div_in_next.den[i] = DEN_W'(FULL2);
            end
            MODE_RGB_P, MODE_P_PP: begin
               div_in_next.num[i] = NUM_W'(ind_ff[i]) + (NUM_W'(as_ff[i]) << 8)
                                    - NUM_W'(as_ff[i]);
               div_in_next.den[i] = DEN_W'(FULL2);
            end
            MODE_N_EN: begin
               div_in_next.num[i] = NUM_W'(s2_ff[i]);
            end
            MODE_N_EP: begin
               if (s2_ff[3] == 8'd0) begin
                  div_in_next.num[i] = '0;
               end else begin
                  div_in_next.num[i] = (NUM_W'(s2_ff[i]) << 8) - NUM_W'(s2_ff[i]);
                  div_in_next.den[i] = DEN_W'(s2_ff[3]);
               end
            end
            MODE_N_NN, MODE_N_NP: begin
               if (k2_ff != 16'd0) begin
                  div_in_next.num[i] = NUM_W'(prod[i])
                     + ((mode2_ff == MODE_N_NN) ? fg4[i] : fg5[i]);
                  div_in_next.den[i] = newa;
               end
            end
            MODE_P_EN: begin
               div_in_next.num[i] = NUM_W'(ks_ff[i]);
               div_in_next.den[i] = DEN_W'(FULL2);
            end
            MODE_P_EP: begin
               div_in_next.num[i] = NUM_W'(as_ff[i]);
               div_in_next.den[i] = DEN_W'(BYTE_MAX);
            end
            default: begin
            end
         endcase
      end
      div_in_next.num[3] = NUM_W'(d2_ff[3]);
      div_in_next.den[3] = DEN_W'(1);
      case (mode2_ff)
         MODE_P_PN, MODE_P_PP: begin
            div_in_next.num[3] = NUM_W'(newa);
            div_in_next.den[3] = DEN_W'(FULL2);
         end
         MODE_N_EN, MODE_N_EP, MODE_P_EN, MODE_P_EP: begin
            div_in_next.num[3] = NUM_W'(k2_ff);
            div_in_next.den[3] = DEN_W'(BYTE_MAX);
         end
         MODE_N_NN, MODE_N_NP: begin
            if (k2_ff != 16'd0) begin
               div_in_next.num[3] = NUM_W'(newa);
               div_in_next.den[3] = DEN_W'(FULL2);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         div_ff.valid <= 1'b0;
      end else begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         div_ff.valid <= div_in_next.valid;
      end
      mode1_ff <= mode1_in;
      a1_ff    <= a1_in;
      k1_ff    <= k1_in;
      s1_ff    <= s1_in;
      d1_ff    <= d1_in;
      mode2_ff <= mode1_ff;
      k2_ff    <= k1_ff;
      s2_ff    <= s1_ff;
      d2_ff    <= d1_ff;
      ind_ff   <= ind_in;
      ks_ff    <= ks_in;
      as_ff    <= as_in;
      ina_ff   <= ina_in;
      invd3_ff <= invd3_in;
      div_ff.num <= div_in_next.num;
      div_ff.den <= div_in_next.den;
   end

   assign div_in = div_ff;

endmodule

FILE: hdl/apb_div.sv
// ----------------------------------------------------------------------------
// Pipelined rounding divider
// Four lanes of round-to-nearest division saturating at 255: a rounding
// register stage, then one quotient bit per register stage.
// ----------------------------------------------------------------------------
module apb_div (
   input  logic                     clock,
   input  logic                     reset,
   input  apb_pkg::apb_div_in_type  div_in,
   output apb_pkg::apb_div_out_type div_out
);
   import apb_pkg::*;

   logic             vld_ff   [0:Q_W];
   logic [REM_W-1:0] rem_ff   [0:Q_W][LANES];
   logic [DEN_W-1:0] den_ff   [0:Q_W][LANES];
   logic [Q_W-1:0]   quo_ff   [0:Q_W][LANES];
   logic             over_ff  [0:Q_W][LANES];
   logic [NUM_W-1:0] sum_in   [LANES];
   logic             over_in  [LANES];
   logic [REM_W-1:0] trial_in [1:Q_W][LANES];
   logic             ge_in    [1:Q_W][LANES];
   logic [REM_W-1:0] rem_in   [1:Q_W][LANES];
   logic [Q_W-1:0]   quo_in   [1:Q_W][LANES];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         sum_in[l]  = div_in.num[l] + NUM_W'(div_in.den[l] >> 1);
         over_in[l] = sum_in[l] >= (NUM_W'(div_in.den[l]) << Q_W);
      end
   end

   always_comb begin
      for (int j = 1; j <= Q_W; j++) begin
         for (int l = 0; l < LANES; l++) begin
            trial_in[j][l] = REM_W'(den_ff[j-1][l]) << (Q_W - j);
            ge_in[j][l]    = rem_ff[j-1][l] >= trial_in[j][l];
            rem_in[j][l]   = ge_in[j][l] ? rem_ff[j-1][l] - trial_in[j][l]
                                         : rem_ff[j-1][l];
            quo_in[j][l]   = quo_ff[j-1][l];
            quo_in[j][l][Q_W-j] = ge_in[j][l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= Q_W; j++) begin
            vld_ff[j] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= div_in.valid;
         for (int j = 1; j <= Q_W; j++) begin
            vld_ff[j] <= vld_ff[j-1];
         end
      end
      for (int l = 0; l < LANES; l++) begin
         rem_ff[0][l]  <= sum_in[l][REM_W-1:0];
         den_ff[0][l]  <= div_in.den[l];
         quo_ff[0][l]  <= '0;
         over_ff[0][l] <= over_in[l];
      end
      for (int j = 1; j <= Q_W; j++) begin
         for (int l = 0; l < LANES; l++) begin
            rem_ff[j][l]  <= rem_in[j][l];
            den_ff[j][l]  <= den_ff[j-1][l];
            quo_ff[j][l]  <= quo_in[j][l];
            over_ff[j][l] <= over_ff[j-1][l];
         end
      end
   end

   always_comb begin
      div_out.valid = vld_ff[Q_W];
      for (int l = 0; l < LANES; l++) begin
         div_out.quo[l] = over_ff[Q_W][l] ? BYTE_MAX : quo_ff[Q_W][l];
      end
   end

endmodule

FILE: hdl/alpha_over_pixel_blender_top.sv
// ----------------------------------------------------------------------------
// Alpha over pixel blender
// Source-over compositing of one 8-bit RGBA pixel per clock.
// ----------------------------------------------------------------------------
// The blender takes one pixel in every clock cycle and returns each result in
// the order of the requests. A pixel passes through three stages of
// multiplication, a rounding stage, a divider that resolves one quotient bit
// per stage over eight stages, and a final output register.
// Busy is high only during reset. Results appear on rsp_data for one cycle
// with rsp_strobe and cannot be stalled. Configuration writes are always ready
// and take effect for pixels started after the write.
module alpha_over_pixel_blender_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  apb_pkg::apb_req_type req_data,
   output logic                 rsp_strobe,
   output apb_pkg::apb_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_data
);
   import apb_pkg::*;

   apb_cfg_type     cfg_ff;
   apb_div_in_type  div_in;
   apb_div_out_type div_out;
   logic            strobe_ff;
   apb_rsp_type     rsp_ff;

   assign busy      = reset;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blend_mode     <= MODE_RGB_N;
         cfg_ff.global_alpha   <= BYTE_MAX;
         cfg_ff.use_mask       <= 1'b0;
         cfg_ff.fill_color     <= '0;
         cfg_ff.use_fill_color <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_BLEND_MODE:     cfg_ff.blend_mode     <= csr_data[3:0];
            REG_GLOBAL_ALPHA:   cfg_ff.global_alpha   <= csr_data[7:0];
            REG_USE_MASK:       cfg_ff.use_mask       <= csr_data[0];
            REG_FILL_COLOR:     cfg_ff.fill_color     <= csr_data;
            REG_USE_FILL_COLOR: cfg_ff.use_fill_color <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   apb_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .req_valid (start && !busy),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .div_in    (div_in)
   );

   apb_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_in  (div_in),
      .div_out (div_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= div_out.valid;
      end
      rsp_ff.out_red   <= div_out.quo[0];
      rsp_ff.out_green <= div_out.quo[1];
      rsp_ff.out_blue  <= div_out.quo[2];
      rsp_ff.out_alpha <= div_out.quo[3];
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

FILE: hdl/apb_checker.sv
// ----------------------------------------------------------------------------
// Alpha blender port checker
// Checks request and result timing, busy and csr ready as seen on the top-level ports.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module apb_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe,
   input logic csr_ready
);
   import apb_pkg::*;

   `APB_ASSERT_ALWAYS(a_never_busy, clock, reset, !busy)
   `APB_ASSERT_IMPLY(a_result_follows, clock, reset, start && !busy, ##LATENCY rsp_strobe)
   `APB_ASSERT_IMPLY(a_result_requested, clock, reset, rsp_strobe, $past(start && !busy, LATENCY))
   `APB_ASSERT_ALWAYS(a_csr_ready, clock, reset, csr_ready)

endmodule

bind alpha_over_pixel_blender_top apb_checker u_apb_checker (.*);
